// File: rtl/ugnb_pkg.sv
package ugnb_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int POS_W      = 16;
   localparam int OBJ_ID_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SHIFT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS  = 2'd2;

   localparam logic [3:0] CELL_SHIFT_RST = 4'd8;
   localparam logic [4:0] GRID_COLS_RST  = 5'd16;
   localparam logic [4:0] GRID_ROWS_RST  = 5'd16;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]   req_type;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [OBJ_ID_W-1:0]     object_id;
   } ugnb_req_type;

   typedef struct packed {
      logic [OBJ_ID_W-1:0] neighbor_id;
      logic                found;
      logic                dropped;
      logic                last;
   } ugnb_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic sweep_start;
      logic sweep_step;
      logic nb_first;
      logic nb_center;
      logic nb_next;
      logic lookup;
      logic id_read;
      logic ins_commit;
      logic emit_done;
      logic emit_end;
   } ugnb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sweep_last;
      logic nb_last;
      logic cell_hit;
      logic id_last;
   } ugnb_sts_type;

endpackage

// File: rtl/ugnb_ctrl.sv
module ugnb_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [ugnb_pkg::REQ_TYPE_W-1:0]       req_type,
   input  ugnb_pkg::ugnb_sts_type                sts,
   output ugnb_pkg::ugnb_cmd_type                cmd,
   output logic                                  busy
);
   import ugnb_pkg::*;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_DONE,
      S_INS_LOOK,
      S_INS_COMMIT,
      S_Q_LOOK,
      S_Q_CNT,
      S_Q_ID,
      S_Q_DRAIN,
      S_Q_END
   } state_type;

   state_type state_ff, state_in;
   logic      from_clear_ff, from_clear_in;
   logic      busy_ff;

   always_comb begin
      state_in      = state_ff;
      from_clear_in = from_clear_ff;
      cmd           = '0;
      case (state_ff)
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = from_clear_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_type)
                  REQ_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     from_clear_in   = 1'b1;
                     state_in        = S_SWEEP;
                  end
                  REQ_INSERT: begin
                     cmd.nb_center = 1'b1;
                     state_in      = S_INS_LOOK;
                  end
                  REQ_QUERY: begin
                     cmd.nb_first = 1'b1;
                     state_in     = S_Q_LOOK;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DONE: begin
            cmd.emit_done = 1'b1;
            state_in      = S_IDLE;
         end
         S_INS_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_INS_COMMIT;
         end
         S_INS_COMMIT: begin
            cmd.ins_commit = 1'b1;
            state_in       = S_IDLE;
         end
         S_Q_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = S_Q_CNT;
         end
         S_Q_CNT: begin
            if (sts.cell_hit) begin
               state_in = S_Q_ID;
            end else if (sts.nb_last) begin
               state_in = S_Q_DRAIN;
            end else begin
               cmd.nb_next = 1'b1;
               state_in    = S_Q_LOOK;
            end
         end
         S_Q_ID: begin
            cmd.id_read = 1'b1;
            if (sts.id_last) begin
               if (sts.nb_last) begin
                  state_in = S_Q_DRAIN;
               end else begin
                  cmd.nb_next = 1'b1;
                  state_in    = S_Q_LOOK;
               end
            end
         end
         // last id read lands here
         S_Q_DRAIN: state_in = S_Q_END;
         S_Q_END: begin
            cmd.emit_end = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         from_clear_ff <= 1'b0;
         busy_ff       <= 1'b1;
      end else begin
         state_ff      <= state_in;
         from_clear_ff <= (state_in == S_SWEEP) ? from_clear_in : 1'b0;
         busy_ff       <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// File: rtl/ugnb_datapath.sv
module ugnb_datapath #(
   parameter int MAX_COLS      = 16,
   parameter int MAX_ROWS      = 16,
   parameter int CELL_CAPACITY = 4,
   parameter int ID_BITS       = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ugnb_pkg::ugnb_req_type                req_data,
   input  logic                                  csr_we,
   input  logic [ugnb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ugnb_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  ugnb_pkg::ugnb_cmd_type                cmd,
   output ugnb_pkg::ugnb_sts_type                sts,
   output logic                                  rsp_valid,
   output ugnb_pkg::ugnb_rsp_type                rsp_data
);
   import ugnb_pkg::*;

   localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
   localparam int ID_DEPTH  = NUM_CELLS * CELL_CAPACITY;
   localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SLOT_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int ID_AW     = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;
   localparam int CNT_W     = $clog2(CELL_CAPACITY + 1);

   // truncate toward zero: shift the magnitude, restore the sign
   function automatic logic signed [16:0] to_cell(logic signed [POS_W-1:0] v,
                                                  logic [3:0] sh);
      logic [16:0] mag;
      logic [16:0] q;
      mag = v[POS_W-1] ? (17'd0 - {v[POS_W-1], v}) : {1'b0, v};
      q   = mag >> sh;
      return v[POS_W-1] ? $signed(17'd0 - q) : $signed(q);
   endfunction

   // configuration
   logic [3:0] shift_ff;
   logic [4:0] cols_ff, rows_ff;

   // request
   logic signed [16:0]  cx_ff, cy_ff;
   logic [ID_BITS-1:0]  oid_ff;

   // walk state
   logic [1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [SLOT_W-1:0]   sweep_ff, sweep_in;
   logic [SLOT_W-1:0]   slot_ff;
   logic                ok_ff;
   logic [CNT_W-1:0]    cnt_rd_ff;
   logic [CNT_W-1:0]    j_ff, j_in;
   logic [ID_BITS-1:0]  id_rd_ff;
   logic                rd_valid_ff;
   logic                pend_valid_ff, pend_valid_in;
   logic [ID_BITS-1:0]  pend_id_ff, pend_id_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ugnb_rsp_type        rsp_ff, rsp_in;

   logic [CNT_W-1:0]    cnt_mem [NUM_CELLS];
   logic [ID_BITS-1:0]  id_mem  [ID_DEPTH];

   logic signed [17:0]  nx_c, ny_c;
   logic [16:0]         cols_lim, rows_lim;
   logic                ok_c, ins_ok;
   logic [SLOT_W-1:0]   slot_c;
   logic [ID_AW-1:0]    wr_addr, rd_addr;

   always_comb begin
      cols_lim = (17'(cols_ff) > 17'(MAX_COLS)) ? 17'(MAX_COLS) : 17'(cols_ff);
      rows_lim = (17'(rows_ff) > 17'(MAX_ROWS)) ? 17'(MAX_ROWS) : 17'(rows_ff);
      nx_c = $signed({cx_ff[16], cx_ff}) + $signed({16'b0, dx_ff}) - 18'sd1;
      ny_c = $signed({cy_ff[16], cy_ff}) + $signed({16'b0, dy_ff}) - 18'sd1;
      ok_c = !nx_c[17] && !ny_c[17] && (nx_c[16:0] < cols_lim) &&
             (ny_c[16:0] < rows_lim);
      slot_c = SLOT_W'(SLOT_W'(ny_c[ROW_W-1:0]) * SLOT_W'(MAX_COLS)) +
               SLOT_W'(nx_c[COL_W-1:0]);
      ins_ok  = ok_ff && (cnt_rd_ff < CNT_W'(CELL_CAPACITY));
      wr_addr = ID_AW'(ID_AW'(slot_ff) * ID_AW'(CELL_CAPACITY)) + ID_AW'(cnt_rd_ff);
      rd_addr = ID_AW'(ID_AW'(slot_ff) * ID_AW'(CELL_CAPACITY)) + ID_AW'(j_ff);
   end

   assign sts.sweep_last = (sweep_ff == SLOT_W'(NUM_CELLS - 1));
   assign sts.nb_last    = (dx_ff == 2'd2) && (dy_ff == 2'd2);
   assign sts.cell_hit   = ok_ff && (cnt_rd_ff != '0);
   assign sts.id_last    = (({1'b0, j_ff} + 1'b1) == {1'b0, cnt_rd_ff});

   always_comb begin
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sweep_in = sweep_ff;
      j_in     = j_ff;
      if (cmd.nb_first) begin
         dx_in = 2'd0;
         dy_in = 2'd0;
      end else if (cmd.nb_center) begin
         dx_in = 2'd1;
         dy_in = 2'd1;
      end else if (cmd.nb_next) begin
         if (dy_ff == 2'd2) begin
            dy_in = 2'd0;
            dx_in = dx_ff + 2'd1;
         end else begin
            dy_in = dy_ff + 2'd1;
         end
      end
      if (cmd.sweep_start) begin
         sweep_in = '0;
      end else if (cmd.sweep_step) begin
         sweep_in = sweep_ff + 1'b1;
      end
      if (cmd.lookup) begin
         j_in = '0;
      end else if (cmd.id_read) begin
         j_in = j_ff + 1'b1;
      end
   end

   // one-deep hold so the final id of a query can carry last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      rsp_in.last   = 1'b1;
      if (rd_valid_ff) begin
         pend_valid_in = 1'b1;
         pend_id_in    = id_rd_ff;
         if (pend_valid_ff) begin
            rsp_valid_in       = 1'b1;
            rsp_in.neighbor_id = OBJ_ID_W'(pend_id_ff);
            rsp_in.found       = 1'b1;
            rsp_in.last        = 1'b0;
         end
      end
      if (cmd.emit_end) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         if (pend_valid_ff) begin
            rsp_in.neighbor_id = OBJ_ID_W'(pend_id_ff);
            rsp_in.found       = 1'b1;
         end
      end
      if (cmd.ins_commit) begin
         rsp_valid_in   = 1'b1;
         rsp_in.dropped = !ins_ok;
      end
      if (cmd.emit_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= CELL_SHIFT_RST;
         cols_ff       <= GRID_COLS_RST;
         rows_ff       <= GRID_ROWS_RST;
         sweep_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CELL_SHIFT: shift_ff <= csr_wdata[3:0];
               CSR_GRID_COLS:  cols_ff  <= csr_wdata;
               CSR_GRID_ROWS:  rows_ff  <= csr_wdata;
               default: ;
            endcase
         end
         sweep_ff      <= sweep_in;
         rd_valid_ff   <= cmd.id_read;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff  <= to_cell(req_data.pos_x, shift_ff);
         cy_ff  <= to_cell(req_data.pos_y, shift_ff);
         oid_ff <= ID_BITS'(req_data.object_id);
      end
      if (cmd.lookup) begin
         slot_ff <= slot_c;
         ok_ff   <= ok_c;
      end
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      j_ff       <= j_in;
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   // bucket counts: one write port, one registered read
   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         cnt_mem[sweep_ff] <= '0;
      end else if (cmd.ins_commit && ins_ok) begin
         cnt_mem[slot_ff] <= cnt_rd_ff + 1'b1;
      end
      if (cmd.lookup) begin
         cnt_rd_ff <= cnt_mem[slot_c];
      end
   end

   // bucket ids
   always_ff @(posedge clock) begin
      if (cmd.ins_commit && ins_ok) begin
         id_mem[wr_addr] <= oid_ff;
      end
      if (cmd.id_read) begin
         id_rd_ff <= id_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/uniform_grid_neighbor_binning.sv
// Insert: after start is taken, a lookup state and a commit state, then the
//   registered result strobe; busy clears with it. Query: a lookup and count
//   check per 3x3 neighbor cell, one read per stored id, a drain, then the
//   final result; ids stream one per cycle within a cell. Clear: one pass over
//   the count memory, then a done result. Reset: a clearing pass with busy high;
//   config writes are taken throughout. The receiver cannot stall results.
module uniform_grid_neighbor_binning #(
   parameter int MAX_COLS      = 16,
   parameter int MAX_ROWS      = 16,
   parameter int CELL_CAPACITY = 4,
   parameter int ID_BITS       = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  ugnb_pkg::ugnb_req_type                req_data,
   output logic                                  rsp_valid,
   output ugnb_pkg::ugnb_rsp_type                rsp_data,
   input  logic                                  csr_we,
   input  logic [ugnb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ugnb_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ugnb_pkg::*;

   ugnb_cmd_type cmd;
   ugnb_sts_type sts;

   ugnb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_data.req_type),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   ugnb_datapath #(
      .MAX_COLS      (MAX_COLS),
      .MAX_ROWS      (MAX_ROWS),
      .CELL_CAPACITY (CELL_CAPACITY),
      .ID_BITS       (ID_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/ugnb_checker.sv
module ugnb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input ugnb_pkg::ugnb_rsp_type rsp_data
);
   import ugnb_pkg::*;

   // a taken request must raise busy; the block keeps it until its results are out
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after transfer");

   a_found_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.found && rsp_data.dropped))
      else $error("found and dropped both set");

   // every non-hit result is the single, final one of its request
   a_miss_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.last && (rsp_data.neighbor_id == '0))
      else $error("non-hit result not final or id nonzero");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result right after final transfer");

   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result with no request in flight");

endmodule

bind uniform_grid_neighbor_binning ugnb_checker u_checker (.*);
